// ===== rtl/core/graph_bfs_dfs_traversal_assert.svh =====
// Assertion macros shared by the traversal block.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GBT_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gbt_pkg.sv =====
package gbt_pkg;

  localparam int VERT_W = 4;
  localparam int ROW_W = 16;
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_BFS = 1'b0;
  localparam logic MODE_DFS = 1'b1;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_UNSEEN = 2'd0;
  localparam mark_t MARK_FOUND = 2'd1;
  localparam mark_t MARK_VISITED = 2'd2;

  typedef struct packed {
    logic [VERT_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic              row_write;
    logic              start;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic hold_valid;
  } back_stat_t;

endpackage

// ===== rtl/core/graph_bfs_dfs_traversal.sv =====
// Row beats pass the front register and the queue and are stored when the idle back end pops them; rows
// stream in one per cycle while the queue has room. A last-row beat starts a traversal that takes each visited
// vertex through the pop, node, load and scan states and a skipped one through pop and node; the scan pushes
// one neighbour per cycle while the pending store has room. The first result appears one vertex late, as each
// vertex is held until the next is known. Synchronous reset clears control state, vertex marks and the queue
// pointers and sets breadth-first mode with 16 vertices; adjacency rows are undefined until written.
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 16,
  parameter int PENDING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // row_index[3:0], row_bits[19:4], zero pad
  input  logic        s_tlast,    // last_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // visit_vertex[3:0], zero pad
  output logic        m_tlast,    // visit_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int ROWS = (MAX_VERTICES < gbt_pkg::ROW_W) ? MAX_VERTICES : gbt_pkg::ROW_W;

  logic                      traversal_mode;
  logic [gbt_pkg::CNT_W-1:0] vertex_count;
  logic                      q_push;
  gbt_pkg::cmd_t             q_in;
  logic                      q_full;
  logic                      q_pop;
  gbt_pkg::cmd_t             q_out;
  logic                      q_valid;
  gbt_pkg::back_stat_t       back_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      traversal_mode <= gbt_pkg::MODE_BFS;
      vertex_count   <= gbt_pkg::CNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gbt_pkg::CFG_MODE:  traversal_mode <= cfg_data[0];
        gbt_pkg::CFG_COUNT: vertex_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  gbt_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  gbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  gbt_back #(
    .ROWS          (ROWS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .traversal_mode (traversal_mode),
    .vertex_count   (vertex_count),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .stat           (back_stat)
  );

`include "graph_bfs_dfs_traversal_assert.svh"

  `GBT_ASSERT_HOLDS(a_idle_no_hold, !back_stat.busy, !back_stat.hold_valid, "vertex held while idle")
  `GBT_ASSERT_NEXT(a_last_ends_run, m_tvalid && m_tready && m_tlast, !m_tvalid, "beat after final vertex")
  `GBT_ASSERT_HOLDS(a_pop_when_idle, q_pop, !back_stat.busy, "queue popped during traversal")

endmodule

// ===== rtl/core/gbt_front.sv =====
module gbt_front #(
  parameter int ROWS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,   // row_index[3:0], row_bits[19:4], zero pad
  input  logic           s_tlast,   // last_row
  output logic           q_push,
  output gbt_pkg::cmd_t  q_data,
  input  logic           q_full
);

  logic          held_valid;
  gbt_pkg::cmd_t held;
  gbt_pkg::cmd_t incoming;

  always_comb begin
    incoming.row_index = s_tdata[gbt_pkg::VERT_W-1:0];
    incoming.row_bits  = s_tdata[gbt_pkg::VERT_W +: gbt_pkg::ROW_W];
    incoming.row_write = ({1'b0, s_tdata[gbt_pkg::VERT_W-1:0]} <
                          gbt_pkg::CNT_W'(ROWS));
    incoming.start     = s_tlast;
  end

  assign s_tready = !held_valid || !q_full;
  assign q_push   = held_valid && !q_full;
  assign q_data   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      held <= incoming;
    end
  end

endmodule

// ===== rtl/core/gbt_queue.sv =====
module gbt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbt_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output gbt_pkg::cmd_t pop_data,
  output logic          not_empty
);

  localparam int AW = (gbt_pkg::QUEUE_DEPTH > 1) ? $clog2(gbt_pkg::QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(gbt_pkg::QUEUE_DEPTH + 1);

  gbt_pkg::cmd_t  slots [gbt_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [LW-1:0]  level;

  assign full      = (level == LW'(gbt_pkg::QUEUE_DEPTH));
  assign not_empty = (level != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(gbt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(gbt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/gbt_back.sv =====
module gbt_back #(
  parameter int ROWS = 16,
  parameter int PENDING_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       traversal_mode,
  input  logic [gbt_pkg::CNT_W-1:0]  vertex_count,
  input  logic                       q_valid,
  input  gbt_pkg::cmd_t              q_data,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,  // visit_vertex[3:0], zero pad
  output logic                       m_tlast,  // visit_last
  output gbt_pkg::back_stat_t        stat
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW = $clog2(PENDING_DEPTH) + 1;
  localparam int VW = gbt_pkg::VERT_W;
  localparam int BW = gbt_pkg::ROW_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_NODE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t         state;
  logic [BW-1:0]  adj_mem [ROWS];
  logic [BW-1:0]  adj_q;
  logic [VW-1:0]  store_mem [PENDING_DEPTH];
  logic [VW-1:0]  store_q;
  gbt_pkg::mark_t marks [ROWS];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [BW-1:0]  cand;
  logic           hold_valid;
  logic [VW-1:0]  hold_vertex;
  logic           out_valid;
  logic [VW-1:0]  out_vertex;
  logic           out_last;

  logic [gbt_pkg::CNT_W-1:0] n_eff;
  logic [BW-1:0]  nmask;
  logic [BW-1:0]  open_bits;
  logic [BW-1:0]  pick_src;
  logic [BW-1:0]  pick_iso;
  logic [VW-1:0]  pick_enc;
  logic [VW-1:0]  pick;
  logic           slot_free;
  logic           is_dfs;
  logic           store_full;
  logic           start_now;
  logic           store_we;
  logic [PW-2:0]  store_wa;
  logic [VW-1:0]  store_wd;
  logic [PW-2:0]  store_ra;
  logic           node_skip;
  logic           node_visit;
  logic           emit;

  assign is_dfs     = (traversal_mode == gbt_pkg::MODE_DFS);
  assign slot_free  = !out_valid || m_tready;
  assign store_full = (tail == PW'(PENDING_DEPTH));
  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign start_now  = q_pop && q_data.start;
  assign node_skip  = is_dfs && (marks[store_q[RW-1:0]] == gbt_pkg::MARK_VISITED);
  assign node_visit = (state == ST_NODE) && !node_skip && slot_free;
  assign emit       = (node_visit && hold_valid) || ((state == ST_DONE) && slot_free);

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = gbt_pkg::CNT_W'(1);
    end else if (vertex_count > gbt_pkg::CNT_W'(ROWS)) begin
      n_eff = gbt_pkg::CNT_W'(ROWS);
    end else begin
      n_eff = vertex_count;
    end
    for (int j = 0; j < BW; j++) begin
      nmask[j] = (gbt_pkg::CNT_W'(j) < n_eff);
    end
  end

  for (genvar j = 0; j < BW; j++) begin : g_open
    if (j < ROWS) begin : g_used
      assign open_bits[j] = is_dfs ? (marks[j] != gbt_pkg::MARK_VISITED)
                                   : (marks[j] == gbt_pkg::MARK_UNSEEN);
    end else begin : g_unused
      assign open_bits[j] = 1'b0;
    end
  end

  // Breadth-first takes the lowest candidate, depth-first the highest.
  always_comb begin
    for (int j = 0; j < BW; j++) begin
      pick_src[j] = is_dfs ? cand[BW-1-j] : cand[j];
    end
    pick_iso = pick_src & (~pick_src + 1'b1);
    pick_enc = '0;
    for (int j = 0; j < BW; j++) begin
      if (pick_iso[j]) begin
        pick_enc = pick_enc | VW'(j);
      end
    end
    pick = is_dfs ? (VW'(BW - 1) - pick_enc) : pick_enc;
  end

  always_comb begin
    store_we = start_now || ((state == ST_SCAN) && (cand != '0) && !store_full);
    store_wa = (state == ST_IDLE) ? '0 : tail[PW-2:0];
    store_wd = (state == ST_IDLE) ? '0 : pick;
    store_ra = is_dfs ? (tail[PW-2:0] - 1'b1) : head[PW-2:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.row_write) begin
      adj_mem[q_data.row_index[RW-1:0]] <= q_data.row_bits;
    end
    if (state == ST_NODE) begin
      adj_q <= adj_mem[store_q[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    if (state == ST_POP) begin
      store_q <= store_mem[store_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int j = 0; j < ROWS; j++) begin
        marks[j] <= gbt_pkg::MARK_UNSEEN;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_now) begin
            for (int j = 1; j < ROWS; j++) begin
              marks[j] <= gbt_pkg::MARK_UNSEEN;
            end
            marks[0] <= is_dfs ? gbt_pkg::MARK_UNSEEN : gbt_pkg::MARK_FOUND;
            head  <= '0;
            tail  <= PW'(1);
            state <= ST_POP;
          end
        end
        ST_POP: begin
          if (is_dfs) begin
            if (tail != '0) begin
              tail  <= tail - 1'b1;
              state <= ST_NODE;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            if (head < tail) begin
              head  <= head + 1'b1;
              state <= ST_NODE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_NODE: begin
          if (node_skip) begin
            state <= ST_POP;
          end else if (slot_free) begin
            // The previous vertex goes out now; the newest one waits, since
            // only the end of the traversal tells whether it is the final one.
            marks[store_q[RW-1:0]] <= gbt_pkg::MARK_VISITED;
            if (hold_valid) begin
              out_vertex <= hold_vertex;
              out_last   <= 1'b0;
            end
            hold_valid  <= 1'b1;
            hold_vertex <= store_q;
            state       <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cand  <= adj_q & nmask & open_bits;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cand != '0) begin
            cand <= cand & ~(BW'(1) << pick);
            marks[pick[RW-1:0]] <= gbt_pkg::MARK_FOUND;
            if (!store_full) begin
              tail <= tail + 1'b1;
            end
          end else begin
            state <= ST_POP;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_vertex <= hold_vertex;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(8 - VW){1'b0}}, out_vertex};
  assign m_tlast  = out_last;

  assign stat.busy       = (state != ST_IDLE);
  assign stat.hold_valid = hold_valid;

endmodule
